@@ rtl/core/fdf_pkg.sv @@
// shared types, constants and helpers for the fixed-point decimal formatter
`default_nettype none

package fdf_pkg;

  localparam int DEF_FRAC_BITS  = 16;
  localparam int DEF_VALUE_BITS = 32;

  localparam int MAX_DIGITS     = 16;
  localparam int DIGIT_BITS     = 4;
  localparam int BCD_BITS       = MAX_DIGITS * DIGIT_BITS;
  localparam int NDIG_BITS      = 5;
  localparam int DP_BITS        = 3;
  localparam int MD_BITS        = 4;
  localparam int DP_MAX         = 6;
  localparam int MD_MAX         = 10;
  localparam int POW10_BITS     = 20;
  localparam int BITS_PER_STEP  = 4;
  localparam int RESET_DP       = 3;
  localparam int RESET_MD       = 3;
  localparam int CFG_IDX_BITS   = 2;
  localparam int CFG_DATA_BITS  = 4;
  localparam int CHAR_BITS      = 8;
  localparam int Q_DEPTH        = 2;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_BITS-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 8'h2D;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_DECIMAL_PLACES = 2'd0,
    CFG_MIN_DIGITS     = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    FR_IDLE,
    FR_SCALE,
    FR_ROUND,
    FR_CONV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SIGN,
    BK_DIGIT,
    BK_POINT
  } back_state_e;

  typedef struct packed {
    logic                 neg;
    logic [BCD_BITS-1:0]  bcd;
    logic [NDIG_BITS-1:0] n_digits;
    logic [DP_BITS-1:0]   dp;
  } fmt_entry_t;

  // number of digits up to and including the highest nonzero one
  function automatic logic [NDIG_BITS-1:0] sig_digits(input logic [BCD_BITS-1:0] bcd);
    logic [NDIG_BITS-1:0] n;
    n = '0;
    for (int i = 0; i < MAX_DIGITS; i++) begin
      if (bcd[i*DIGIT_BITS +: DIGIT_BITS] != '0) begin
        n = NDIG_BITS'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/fdf_front.sv @@
// front end: takes a value, scales by a power of ten, rounds, converts to bcd
`default_nettype none

module fdf_front #(
  parameter int FRAC_BITS  = fdf_pkg::DEF_FRAC_BITS,
  parameter int VALUE_BITS = fdf_pkg::DEF_VALUE_BITS
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0]      value_i,
  input  wire logic [fdf_pkg::DP_BITS-1:0]       dp_i,
  input  wire logic [fdf_pkg::MD_BITS-1:0]       md_i,
  output logic                                   push_valid_o,
  input  wire logic                              push_ready_i,
  output fdf_pkg::fmt_entry_t                    push_entry_o
);

  localparam int PROD_BITS   = VALUE_BITS + fdf_pkg::POW10_BITS;
  localparam int ACC_BITS    = ((PROD_BITS > FRAC_BITS) ? PROD_BITS : FRAC_BITS) + 1;
  localparam int SCALED_BITS = ACC_BITS - FRAC_BITS;
  localparam int DD_STEPS    = (SCALED_BITS + fdf_pkg::BITS_PER_STEP - 1)
                               / fdf_pkg::BITS_PER_STEP;
  localparam int DD_BITS     = DD_STEPS * fdf_pkg::BITS_PER_STEP;
  localparam int STEP_BITS   = $clog2(DD_STEPS + 1);
  localparam int HALF_SHIFT  = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam logic [ACC_BITS-1:0] HALF = (FRAC_BITS > 0) ?
                                         (ACC_BITS'(1) << HALF_SHIFT) : '0;

  fdf_pkg::front_state_e                 state_q, state_d;
  logic                                  neg_q, neg_d;
  logic [fdf_pkg::DP_BITS-1:0]           dp_q, dp_d;
  logic [fdf_pkg::NDIG_BITS-1:0]         cnt_q, cnt_d;
  logic [fdf_pkg::DP_BITS-1:0]           mul_q, mul_d;
  logic [ACC_BITS-1:0]                   acc_q, acc_d;
  logic [DD_BITS-1:0]                    sreg_q, sreg_d;
  logic [fdf_pkg::BCD_BITS-1:0]          bcd_q, bcd_d;
  logic                                  ovf_q, ovf_d;
  logic [STEP_BITS-1:0]                  step_q, step_d;

  logic [VALUE_BITS-1:0]                 raw;
  logic [VALUE_BITS-1:0]                 mag;
  logic [fdf_pkg::DP_BITS-1:0]           dp_sat;
  logic [fdf_pkg::MD_BITS-1:0]           md_sat;
  logic [ACC_BITS-1:0]                   rounded;
  logic [fdf_pkg::BCD_BITS-1:0]          b;
  logic [DD_BITS-1:0]                    s;
  logic                                  o;
  logic [fdf_pkg::NDIG_BITS-1:0]         sig;

  assign raw = value_i;
  assign mag = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

  assign dp_sat = (dp_i > fdf_pkg::DP_BITS'(fdf_pkg::DP_MAX)) ?
                  fdf_pkg::DP_BITS'(fdf_pkg::DP_MAX) : dp_i;
  assign md_sat = (md_i == '0) ? fdf_pkg::MD_BITS'(1) :
                  (md_i > fdf_pkg::MD_BITS'(fdf_pkg::MD_MAX)) ?
                  fdf_pkg::MD_BITS'(fdf_pkg::MD_MAX) : md_i;

  assign rounded = acc_q + HALF;

  assign in_stall_o = (state_q != fdf_pkg::FR_IDLE);

  assign sig = fdf_pkg::sig_digits(bcd_q);
  always_comb begin
    push_entry_o.neg      = neg_q;
    push_entry_o.bcd      = bcd_q;
    push_entry_o.dp       = dp_q;
    if (ovf_q) begin
      push_entry_o.n_digits = fdf_pkg::NDIG_BITS'(fdf_pkg::MAX_DIGITS);
    end else begin
      push_entry_o.n_digits = (sig > cnt_q) ? sig : cnt_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    neg_d        = neg_q;
    dp_d         = dp_q;
    cnt_d        = cnt_q;
    mul_d        = mul_q;
    acc_d        = acc_q;
    sreg_d       = sreg_q;
    bcd_d        = bcd_q;
    ovf_d        = ovf_q;
    step_d       = step_q;
    push_valid_o = 1'b0;
    b            = bcd_q;
    s            = sreg_q;
    o            = ovf_q;
    case (state_q)
      fdf_pkg::FR_IDLE: begin
        if (in_valid_i) begin
          neg_d   = raw[VALUE_BITS-1];
          dp_d    = dp_sat;
          cnt_d   = fdf_pkg::NDIG_BITS'(md_sat) + fdf_pkg::NDIG_BITS'(dp_sat);
          mul_d   = dp_sat;
          acc_d   = ACC_BITS'(mag);
          state_d = fdf_pkg::FR_SCALE;
        end
      end
      fdf_pkg::FR_SCALE: begin
        if (mul_q == '0) begin
          state_d = fdf_pkg::FR_ROUND;
        end else begin
          // times ten as 8x + 2x
          acc_d = (acc_q << 3) + (acc_q << 1);
          mul_d = mul_q - 1'b1;
        end
      end
      fdf_pkg::FR_ROUND: begin
        sreg_d  = DD_BITS'(rounded >> FRAC_BITS);
        bcd_d   = '0;
        ovf_d   = 1'b0;
        step_d  = STEP_BITS'(DD_STEPS);
        state_d = fdf_pkg::FR_CONV;
      end
      fdf_pkg::FR_CONV: begin
        // double dabble, a few bits per cycle; digits beyond the top one drop out
        for (int k = 0; k < fdf_pkg::BITS_PER_STEP; k++) begin
          for (int d = 0; d < fdf_pkg::MAX_DIGITS; d++) begin
            if (b[d*fdf_pkg::DIGIT_BITS +: fdf_pkg::DIGIT_BITS] >= 4'd5) begin
              b[d*fdf_pkg::DIGIT_BITS +: fdf_pkg::DIGIT_BITS] =
                b[d*fdf_pkg::DIGIT_BITS +: fdf_pkg::DIGIT_BITS] + 4'd3;
            end
          end
          o = o | b[fdf_pkg::BCD_BITS-1];
          b = {b[fdf_pkg::BCD_BITS-2:0], s[DD_BITS-1]};
          s = s << 1;
        end
        bcd_d  = b;
        sreg_d = s;
        ovf_d  = o;
        step_d = step_q - 1'b1;
        if (step_q == STEP_BITS'(1)) begin
          state_d = fdf_pkg::FR_PUSH;
        end
      end
      fdf_pkg::FR_PUSH: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          state_d = fdf_pkg::FR_IDLE;
        end
      end
      default: begin
        state_d = fdf_pkg::FR_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fdf_pkg::FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    dp_q   <= dp_d;
    cnt_q  <= cnt_d;
    mul_q  <= mul_d;
    acc_q  <= acc_d;
    sreg_q <= sreg_d;
    bcd_q  <= bcd_d;
    ovf_q  <= ovf_d;
    step_q <= step_d;
  end

  // an accepted word keeps the front busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("front accepted back-to-back words");

  // a pushed entry always carries between one and sixteen digits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_valid_o |-> (push_entry_o.n_digits != '0) &&
                     (push_entry_o.n_digits <= fdf_pkg::NDIG_BITS'(fdf_pkg::MAX_DIGITS)))
    else $error("digit count out of range");

endmodule

`default_nettype wire

@@ rtl/core/fdf_queue.sv @@
// two-entry queue between the converter front end and the character emitter
`default_nettype none

module fdf_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_valid_i,
  output logic                      push_ready_o,
  input  wire fdf_pkg::fmt_entry_t  push_entry_i,
  output logic                      pop_valid_o,
  input  wire logic                 pop_ready_i,
  output fdf_pkg::fmt_entry_t       pop_entry_o
);

  localparam int PTR_BITS = (fdf_pkg::Q_DEPTH > 1) ? $clog2(fdf_pkg::Q_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(fdf_pkg::Q_DEPTH + 1);

  fdf_pkg::fmt_entry_t     mem_q [fdf_pkg::Q_DEPTH];
  logic [PTR_BITS-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]     count_q, count_d;
  logic                    do_push;
  logic                    do_pop;

  assign push_ready_o = (count_q != CNT_BITS'(fdf_pkg::Q_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;
  assign pop_entry_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_BITS'(fdf_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_BITS'(fdf_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

  // fill level never passes the depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_BITS'(fdf_pkg::Q_DEPTH))
    else $error("queue fill level overflow");

endmodule

`default_nettype wire

@@ rtl/core/fdf_back.sv @@
// back end: walks one queued entry and sends its characters one word at a time
`default_nettype none

module fdf_back (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              pop_valid_i,
  output logic                                   pop_ready_o,
  input  wire fdf_pkg::fmt_entry_t               pop_entry_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [fdf_pkg::CHAR_BITS-1:0]          char_code_o,
  output logic                                   last_o
);

  localparam int IDX_BITS = $clog2(fdf_pkg::MAX_DIGITS);

  fdf_pkg::back_state_e                 state_q, state_d;
  logic                                 neg_q, neg_d;
  logic [fdf_pkg::BCD_BITS-1:0]         bcd_q, bcd_d;
  logic [fdf_pkg::DP_BITS-1:0]          dp_q, dp_d;
  logic [IDX_BITS-1:0]                  idx_q, idx_d;
  logic                                 out_valid_q, out_valid_d;
  logic [fdf_pkg::CHAR_BITS-1:0]        char_q, char_d;
  logic                                 last_q, last_d;

  logic                                 slot_free;
  logic [fdf_pkg::DIGIT_BITS-1:0]       digit;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign digit       = bcd_q[{idx_q, 2'b00} +: fdf_pkg::DIGIT_BITS];
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_o      = last_q;

  always_comb begin
    state_d     = state_q;
    neg_d       = neg_q;
    bcd_d       = bcd_q;
    dp_d        = dp_q;
    idx_d       = idx_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    pop_ready_o = 1'b0;
    case (state_q)
      fdf_pkg::BK_IDLE: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          neg_d   = pop_entry_i.neg;
          bcd_d   = pop_entry_i.bcd;
          dp_d    = pop_entry_i.dp;
          idx_d   = IDX_BITS'(pop_entry_i.n_digits - 1'b1);
          state_d = pop_entry_i.neg ? fdf_pkg::BK_SIGN : fdf_pkg::BK_DIGIT;
        end
      end
      fdf_pkg::BK_SIGN: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = fdf_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          state_d     = fdf_pkg::BK_DIGIT;
        end
      end
      fdf_pkg::BK_DIGIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = fdf_pkg::CHAR_ZERO + fdf_pkg::CHAR_BITS'(digit);
          last_d      = (idx_q == '0);
          if (idx_q == '0) begin
            state_d = fdf_pkg::BK_IDLE;
          end else begin
            idx_d = idx_q - 1'b1;
            // point goes right after the digit whose place equals the decimal count
            if ((dp_q != '0) && (IDX_BITS'(dp_q) == idx_q)) begin
              state_d = fdf_pkg::BK_POINT;
            end
          end
        end
      end
      fdf_pkg::BK_POINT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          char_d      = fdf_pkg::CHAR_POINT;
          last_d      = 1'b0;
          state_d     = fdf_pkg::BK_DIGIT;
        end
      end
      default: begin
        state_d = fdf_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fdf_pkg::BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    bcd_q  <= bcd_d;
    dp_q   <= dp_d;
    idx_q  <= idx_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  // the closing character of a number is always a digit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> (char_code_o >= fdf_pkg::CHAR_ZERO) &&
                              (char_code_o <= fdf_pkg::CHAR_ZERO + 8'd9))
    else $error("last flag on a non-digit character");

  // a sign is only ever sent for a negative entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fdf_pkg::BK_SIGN |-> neg_q)
    else $error("sign state on a positive entry");

endmodule

`default_nettype wire

@@ rtl/core/fixed_decimal_formatter_top.sv @@
// front end takes one value at a time and stalls input until its entry is pushed
// it scales, rounds and converts each value to bcd, then pushes it into the queue
// back end loads an entry from the queue, then sends one char per cycle unless stalled
// the two-entry queue lets both ends overlap; the slower one limits the value rate
// reset: decimal_places = 3, min_digits = 3, queue and output emptied
`default_nettype none

module fixed_decimal_formatter_top #(
  parameter int FRAC_BITS  = fdf_pkg::DEF_FRAC_BITS,
  parameter int VALUE_BITS = fdf_pkg::DEF_VALUE_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  in_valid_i,
  output logic                                       in_stall_o,
  input  wire logic signed [VALUE_BITS-1:0]          value_i,
  output logic                                       out_valid_o,
  input  wire logic                                  out_stall_i,
  output logic [fdf_pkg::CHAR_BITS-1:0]              char_code_o,
  output logic                                       last_o,
  input  wire logic                                  cfg_valid_i,
  output logic                                       cfg_ready_o,
  input  wire logic [fdf_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  wire logic [fdf_pkg::CFG_DATA_BITS-1:0]     cfg_data_i
);

  logic [fdf_pkg::DP_BITS-1:0]  dp_q, dp_d;
  logic [fdf_pkg::MD_BITS-1:0]  md_q, md_d;

  logic                         push_valid;
  logic                         push_ready;
  fdf_pkg::fmt_entry_t          push_entry;
  logic                         pop_valid;
  logic                         pop_ready;
  fdf_pkg::fmt_entry_t          pop_entry;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    dp_d = dp_q;
    md_d = md_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (fdf_pkg::cfg_reg_e'(cfg_index_i))
        fdf_pkg::CFG_DECIMAL_PLACES: begin
          dp_d = cfg_data_i[fdf_pkg::DP_BITS-1:0];
        end
        fdf_pkg::CFG_MIN_DIGITS: begin
          md_d = cfg_data_i[fdf_pkg::MD_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_q <= fdf_pkg::DP_BITS'(fdf_pkg::RESET_DP);
      md_q <= fdf_pkg::MD_BITS'(fdf_pkg::RESET_MD);
    end else begin
      dp_q <= dp_d;
      md_q <= md_d;
    end
  end

  fdf_front #(
    .FRAC_BITS  (FRAC_BITS),
    .VALUE_BITS (VALUE_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .value_i      (value_i),
    .dp_i         (dp_q),
    .md_i         (md_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  fdf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  fdf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_o      (last_o)
  );

endmodule

`default_nettype wire
